// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the checksum verifier RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is off while reset is asserted
`define BCV_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset
`define BCV_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/bcv_pkg.sv =====
// Types, constants and the CRC32C byte update for the checksum verifier
package bcv_pkg;

  localparam int DATA_W              = 8;
  localparam int CRC_W               = 32;
  localparam int OFFSET_W            = 16;
  localparam int SUM_W               = 64;
  localparam int FIELD_BYTES         = 8;
  localparam int MAX_BLOCK_BYTES_DEF = 65536;

  localparam logic [CRC_W-1:0] CRC_POLY = 32'h82F6_3B78;
  localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;

  // One byte request as held in the input register
  typedef struct packed {
    logic [DATA_W-1:0] data_byte;
    logic              last_byte;
  } bcv_item_t;

  // Reflected CRC32C, one byte, bit by bit
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                input logic [DATA_W-1:0] data);
    logic [CRC_W-1:0] c;
    c = crc_in ^ {{(CRC_W-DATA_W){1'b0}}, data};
    for (int k = 0; k < DATA_W; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/bcv_if.sv =====
// Valid/ready channel interfaces for byte requests and verify results
interface bcv_in_if import bcv_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_byte;
  logic              last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface bcv_out_if import bcv_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             checksum_ok;
  logic [CRC_W-1:0] crc_value;
  logic             length_error;

  modport source (output valid, output checksum_ok, output crc_value,
                  output length_error, input ready);
  modport sink   (input valid, input checksum_ok, input crc_value,
                  input length_error, output ready);
endinterface

// ===== rtl/core/bcv_in_stage.sv =====
// Input register: captures one byte request per cycle while it is empty or its held request moves on
module bcv_in_stage import bcv_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  bcv_in_if.sink     in_if,
  input  logic       advance,
  output logic       item_valid,
  output bcv_item_t  item
);

  logic      valid_r, valid_nxt;
  bcv_item_t item_r;
  logic      accept;

  // Room when empty or when the held request moves on this cycle
  assign in_if.ready = !valid_r || advance;
  assign accept      = in_if.valid && in_if.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.data_byte <= in_if.data_byte;
      item_r.last_byte <= in_if.last_byte;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// ===== rtl/core/bcv_verify.sv =====
// CRC update, checksum field capture and result register
module bcv_verify import bcv_pkg::*; #(
  parameter int MAX_BLOCK_BYTES = MAX_BLOCK_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                item_valid,
  input  bcv_item_t           item,
  input  logic [OFFSET_W-1:0] cfg_offset,
  output logic                advance,
  bcv_out_if.source           out_if
);

  `include "assert_macros.svh"

  localparam int POS_W = $clog2(MAX_BLOCK_BYTES + 1);
  localparam int CMP_W = (POS_W > OFFSET_W + 1) ? POS_W : OFFSET_W + 1;
  localparam logic [CMP_W-1:0] MAX_C   = CMP_W'(MAX_BLOCK_BYTES);
  localparam logic [CMP_W-1:0] FIELD_C = CMP_W'(FIELD_BYTES);

  logic [CRC_W-1:0] crc_r, crc_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic             ok_r;
  logic [CRC_W-1:0] crc_out_r;
  logic             len_err_r;

  logic [CMP_W-1:0] pos_ext, off_ext, field_end, pos_inc;
  logic             below_max, in_field, len_err, sum_ok;
  logic [2:0]       lane;
  logic [DATA_W-1:0] feed;
  logic [CRC_W-1:0] crc_upd, crc_final;
  logic [SUM_W-1:0] sum_upd;

  // A last-byte request needs the result register free (or leaving)
  assign advance = item_valid && (!item.last_byte || !out_valid_r || out_if.ready);

  // Field window and position bookkeeping
  always_comb begin
    pos_ext   = CMP_W'(pos_r);
    off_ext   = CMP_W'(cfg_offset);
    field_end = off_ext + FIELD_C;
    below_max = pos_ext < MAX_C;
    in_field  = below_max && (pos_ext >= off_ext) && (pos_ext < field_end);
    lane      = pos_r[2:0] - cfg_offset[2:0];
    pos_inc   = below_max ? pos_ext + CMP_W'(1) : pos_ext;
    len_err   = (field_end > MAX_C) || (pos_inc < field_end);
  end

  // Field bytes go into the stored checksum and enter the CRC as zero
  always_comb begin
    sum_upd = sum_r;
    feed    = item.data_byte;
    if (in_field) begin
      sum_upd[{lane, 3'b000} +: DATA_W] = item.data_byte;
      feed = '0;
    end
    crc_upd   = crc_byte(crc_r, feed);
    crc_final = ~crc_upd;
    sum_ok    = (sum_upd[SUM_W-1:CRC_W] == '0) && (sum_upd[CRC_W-1:0] == crc_final);
  end

  // Block state: cleared after the last byte
  always_comb begin
    crc_nxt = crc_r;
    pos_nxt = pos_r;
    sum_nxt = sum_r;
    if (advance) begin
      if (item.last_byte) begin
        crc_nxt = CRC_INIT;
        pos_nxt = '0;
        sum_nxt = '0;
      end else begin
        crc_nxt = crc_upd;
        pos_nxt = POS_W'(pos_inc);
        sum_nxt = sum_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= CRC_INIT;
      pos_r <= '0;
      sum_r <= '0;
    end else begin
      crc_r <= crc_nxt;
      pos_r <= pos_nxt;
      sum_r <= sum_nxt;
    end
  end

  // Result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance && item.last_byte) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item.last_byte) begin
      ok_r      <= !len_err && sum_ok;
      crc_out_r <= crc_final;
      len_err_r <= len_err;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.checksum_ok  = ok_r;
  assign out_if.crc_value    = crc_out_r;
  assign out_if.length_error = len_err_r;

  // Checks
  `BCV_ASSERT(a_ok_excl_len_err, clk, rst_n, out_valid_r |-> !(ok_r && len_err_r), "checksum_ok with length_error")
  `BCV_ASSERT(a_clear_after_last, clk, rst_n, (advance && item.last_byte) |=> (pos_r == '0 && crc_r == CRC_INIT && sum_r == '0), "block state not cleared after last byte")
  `BCV_ASSERT(a_pos_limit, clk, rst_n, CMP_W'(pos_r) <= MAX_C, "byte position past block limit")
  `BCV_ASSERT(a_no_drop_result, clk, rst_n, (out_valid_r && !out_if.ready) |-> !(advance && item.last_byte), "result overwritten while pending")

endmodule

// ===== rtl/core/block_crc32c_verifier_core.sv =====
// Block CRC32C verifier: takes a block one byte per request, marked by a last
// flag, and returns one result per block with the final CRC32C (init all ones,
// final inversion, reflected polynomial 0x82F63B78), a match flag and a
// length error flag. The eight bytes at cfg offset count as zero in the CRC
// and are captured little-endian as the stored checksum. One byte is taken
// every cycle unless a waiting result stalls input; the byte-wide CRC update
// sits in a single stage between the input register and the result register,
// which is loaded as the block's last byte leaves the input register. A
// waiting result stalls input only once the next block's last byte reaches
// the update stage. Write the offset only while no block is in flight.
module block_crc32c_verifier_core import bcv_pkg::*; #(
  parameter int MAX_BLOCK_BYTES = MAX_BLOCK_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [OFFSET_W-1:0] cfg_wr_data,
  bcv_in_if.sink              in_if,
  bcv_out_if.source           out_if
);

  logic [OFFSET_W-1:0] cfg_offset_r;
  logic                advance;
  logic                item_valid;
  bcv_item_t           item;

  // Checksum offset register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_offset_r <= '0;
    end else if (cfg_wr_en) begin
      cfg_offset_r <= cfg_wr_data;
    end
  end

  bcv_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_if),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  bcv_verify #(
    .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES)
  ) u_verify (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .cfg_offset (cfg_offset_r),
    .advance    (advance),
    .out_if     (out_if)
  );

endmodule

// ===== bench/block_crc32c_verifier_checker.sv =====
// Checker for the block CRC32C verifier: tracks blocks, predicts verdicts, compares results
module block_crc32c_verifier_checker import bcv_pkg::*; #(
  parameter int MAX_BLOCK_BYTES = MAX_BLOCK_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [OFFSET_W-1:0] cfg_wr_data,
  bcv_in_if                   req_if,
  bcv_out_if                  rsp_if,
  output int                  fails,
  output int                  pending,
  output int                  verdicts,
  output int                  ok_blocks,
  output int                  short_blocks
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CRC_W-1:0] CASTAGNOLI_REFL = 32'h82F6_3B78;

  typedef struct packed {
    logic             checksum_ok;
    logic [CRC_W-1:0] crc_value;
    logic             length_error;
  } verdict_t;

  // Predictor state: offset register and the running per-block values
  logic [OFFSET_W-1:0] offset_q;
  logic [CRC_W-1:0]    crc_acc;
  int                  byte_idx;
  logic [SUM_W-1:0]    field_sum;
  verdict_t            verdict_q[$];
  int                  fail_tally;
  int                  verdict_tally;
  int                  match_tally;
  int                  short_tally;

  // Reflected CRC32C, LSB of the byte first, one shift per bit
  function automatic logic [CRC_W-1:0] crc32c_advance(input logic [CRC_W-1:0] acc,
                                                      input logic [DATA_W-1:0] b);
    logic fb;
    for (int i = 0; i < DATA_W; i++) begin
      fb  = acc[0] ^ b[i];
      acc = {1'b0, acc[CRC_W-1:1]} ^ (fb ? CASTAGNOLI_REFL : '0);
    end
    return acc;
  endfunction

  function automatic bit field_matches(input string name, input logic [CRC_W-1:0] want,
                                       input logic [CRC_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %08h, actual %08h", $time, name, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin : track
    logic [DATA_W-1:0] feed;
    logic [CRC_W-1:0]  final_crc;
    int                off_i;
    int                field_end;
    verdict_t          want;
    if (!rst_n) begin
      offset_q      = '0;
      crc_acc       = '1;
      byte_idx      = 0;
      field_sum     = '0;
      verdict_q.delete();
      fail_tally    = 0;
      verdict_tally = 0;
      match_tally   = 0;
      short_tally   = 0;
    end else begin
      // Byte request: field bytes are captured and fed as zero
      if (req_if.valid && req_if.ready) begin
        off_i     = int'(offset_q);
        field_end = off_i + FIELD_BYTES;
        feed      = req_if.data_byte;
        if (byte_idx < MAX_BLOCK_BYTES && byte_idx >= off_i && byte_idx < field_end) begin
          field_sum[8*(byte_idx - off_i) +: 8] = req_if.data_byte;
          feed = '0;
        end
        crc_acc = crc32c_advance(crc_acc, feed);
        // position saturates at the block limit
        if (byte_idx < MAX_BLOCK_BYTES) byte_idx++;
        if (req_if.last_byte) begin
          final_crc          = ~crc_acc;
          want.crc_value     = final_crc;
          want.length_error  = (field_end > MAX_BLOCK_BYTES) || (byte_idx < field_end);
          want.checksum_ok   = !want.length_error && (field_sum == {32'h0, final_crc});
          verdict_q.push_back(want);
          crc_acc   = '1;
          byte_idx  = 0;
          field_sum = '0;
        end
      end

      // Result request: compare with the oldest prediction
      if (rsp_if.valid && rsp_if.ready) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual ok=%0b crc=%08h len_err=%0b",
                   $time, rsp_if.checksum_ok, rsp_if.crc_value, rsp_if.length_error);
          fail_tally++;
        end else begin
          want = verdict_q.pop_front();
          verdict_tally++;
          if (want.checksum_ok) match_tally++;
          if (want.length_error) short_tally++;
          if (!field_matches("checksum_ok", CRC_W'(want.checksum_ok),
                             CRC_W'(rsp_if.checksum_ok)))
            fail_tally++;
          if (!field_matches("crc_value", want.crc_value, rsp_if.crc_value))
            fail_tally++;
          if (!field_matches("length_error", CRC_W'(want.length_error),
                             CRC_W'(rsp_if.length_error)))
            fail_tally++;
        end
      end

      // New offset applies from the next byte on
      if (cfg_wr_en) offset_q = cfg_wr_data;
    end
    fails        <= fail_tally;
    pending      <= verdict_q.size();
    verdicts     <= verdict_tally;
    ok_blocks    <= match_tally;
    short_blocks <= short_tally;
  end

endmodule

// ===== bench/block_crc32c_verifier_core_test.sv =====
// Top of the block CRC32C verifier bench: clock, reset, block stimulus and verdict
module block_crc32c_verifier_core_test import bcv_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BLOCK_LIMIT     = 512;
  localparam int ITEM_TARGET     = 1950;
  localparam int HOLD_CYCLES     = 150;
  localparam int WATCHDOG_CYCLES = 4000;

  typedef enum logic [1:0] {
    BLOCK_SEALED,    // field holds the correct CRC
    BLOCK_TAMPERED,  // correct CRC with one bit of the field flipped
    BLOCK_RAW        // random bytes throughout
  } block_kind_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_wr_en;
  logic [OFFSET_W-1:0] cfg_wr_data;
  logic                steady;
  logic                hold_req;
  int                  cur_offset;
  int                  bytes_sent;
  int                  offsets_set;
  int                  idle_cycles;
  int                  fails;
  int                  pending;
  int                  verdicts;
  int                  ok_blocks;
  int                  short_blocks;

  bcv_in_if  req_if ();
  bcv_out_if rsp_if ();

  block_crc32c_verifier_core #(
    .MAX_BLOCK_BYTES(BLOCK_LIMIT)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_if      (req_if),
    .out_if     (rsp_if)
  );

  block_crc32c_verifier_checker #(
    .MAX_BLOCK_BYTES(BLOCK_LIMIT)
  ) checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req_if      (req_if),
    .rsp_if      (rsp_if),
    .fails       (fails),
    .pending     (pending),
    .verdicts    (verdicts),
    .ok_blocks   (ok_blocks),
    .short_blocks(short_blocks)
  );

  always #5ns clk = ~clk;

  // Result side: random stalls, none while steady, and one long hold-off on request that overrides steady
  initial begin : result_sink
    int hold_left;
    bit hold_taken;
    hold_left  = 0;
    hold_taken = 1'b0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        rsp_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
        rsp_if.ready <= 1'b0;
      end else if (steady) begin
        rsp_if.ready <= 1'b1;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= 14);
      end
    end
  end

  // Watchdog: too long without any request moving on either side
  always @(posedge clk) begin
    if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("%0t: no progress for %0d cycles", $time, WATCHDOG_CYCLES);
      $display("[block_crc32c_verifier_core] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic bit in_field(input int pos);
    return pos >= cur_offset && pos < cur_offset + FIELD_BYTES && pos < BLOCK_LIMIT;
  endfunction

  // One byte request, with a random gap in front unless steady
  task automatic push_byte(input logic [DATA_W-1:0] d, input logic last);
    while (!steady && $urandom_range(99) < 14) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid     <= 1'b1;
    req_if.data_byte <= d;
    req_if.last_byte <= last;
    do @(posedge clk); while (!req_if.ready);
    bytes_sent++;
  endtask

  // Build a block against the current offset and stream it out
  task automatic send_block(input int len, input block_kind_t kind);
    logic [DATA_W-1:0] block_q[$];
    logic [CRC_W-1:0]  sum;
    int                bit_sel;
    int                idx;
    for (int i = 0; i < len; i++) block_q.push_back(8'($urandom_range(255)));
    if (kind != BLOCK_RAW) begin
      sum = CRC_INIT;
      for (int i = 0; i < len; i++) sum = crc_byte(sum, in_field(i) ? 8'h00 : block_q[i]);
      sum = ~sum;
      for (int k = 0; k < FIELD_BYTES; k++) begin
        idx = cur_offset + k;
        if (idx < len && in_field(idx)) block_q[idx] = (k < 4) ? sum[8*k +: 8] : 8'h00;
      end
      if (kind == BLOCK_TAMPERED && cur_offset + FIELD_BYTES <= len) begin
        bit_sel = $urandom_range(63);
        idx     = cur_offset + bit_sel / 8;
        block_q[idx] = block_q[idx] ^ (8'h01 << (bit_sel % 8));
      end
    end
    for (int i = 0; i < len; i++) push_byte(block_q[i], i == len - 1);
  endtask

  // Sender stops until every outstanding result has been taken
  task automatic drain_results();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_checksum_offset(input int value);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= OFFSET_W'(value);
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    cur_offset = value;
    offsets_set++;
  endtask

  // Random block shaped around the current offset
  task automatic send_random_block();
    int pick;
    pick = $urandom_range(99);
    if (pick < 65)
      send_block(cur_offset + FIELD_BYTES + $urandom_range(10), BLOCK_SEALED);
    else if (pick < 80)
      send_block(cur_offset + FIELD_BYTES + $urandom_range(10), BLOCK_TAMPERED);
    else if (pick < 92)
      send_block($urandom_range(1, cur_offset + FIELD_BYTES - 1), BLOCK_SEALED);
    else
      send_block($urandom_range(1, cur_offset + 20), BLOCK_RAW);
  endtask

  initial begin : stimulus
    int phase;
    int pick;
    rst_n            <= 1'b0;
    cfg_wr_en        <= 1'b0;
    cfg_wr_data      <= '0;
    req_if.valid     <= 1'b0;
    req_if.data_byte <= '0;
    req_if.last_byte <= 1'b0;
    steady           <= 1'b0;
    hold_req         <= 1'b0;
    cur_offset  = 0;
    bytes_sent  = 0;
    offsets_set = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: one-byte blocks at the data extremes, field at the very start
    set_checksum_offset(0);
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b1);
    send_block(8, BLOCK_SEALED);
    send_block(12, BLOCK_SEALED);

    // Receiver holds off while short blocks keep coming, so the block backs up
    set_checksum_offset(3);
    steady   <= 1'b1;
    hold_req <= 1'b1;
    repeat (40) send_block($urandom_range(1, 2), BLOCK_RAW);
    steady <= 1'b0;

    // Field ending right at the block limit, then a block running past the limit
    set_checksum_offset(BLOCK_LIMIT - FIELD_BYTES);
    send_block(BLOCK_LIMIT + 4, BLOCK_SEALED);
    repeat (3) send_block($urandom_range(1, 30), BLOCK_RAW);

    // Field can never complete: one byte past the limit, and offset 65528
    set_checksum_offset(BLOCK_LIMIT - FIELD_BYTES + 1);
    repeat (4) send_block($urandom_range(1, 30), BLOCK_RAW);
    set_checksum_offset(65528);
    repeat (4) send_block($urandom_range(1, 30), BLOCK_SEALED);

    // Random phases, one of them with no idling on either side
    phase = 0;
    while (bytes_sent < ITEM_TARGET) begin
      pick = $urandom_range(99);
      if (pick < 10)
        set_checksum_offset(0);
      else if (pick < 20)
        set_checksum_offset($urandom_range(25, 60));
      else
        set_checksum_offset($urandom_range(1, 24));
      steady <= (phase == 2);
      repeat ($urandom_range(6, 14)) send_random_block();
      steady <= 1'b0;
      phase++;
    end

    drain_results();
    repeat (8) @(posedge clk);
    $display("Checked %0d blocks over %0d bytes: %0d checksum matches, %0d length errors.",
             verdicts, bytes_sent, ok_blocks, short_blocks);
    $display("Used %0d offset settings, a long result hold-off and an overlong block.",
             offsets_set);
    if (fails == 0 && pending == 0) begin
      $display("[block_crc32c_verifier_core] OK");
    end else begin
      $display("[block_crc32c_verifier_core] ERROR");
    end
    $finish;
  end

endmodule
